[sv/lztsd_pkg.sv]
package lztsd_pkg;

	localparam int HISTORY_DEPTH_DEF    = 4096;
	localparam int BYTES_PER_RESULT_DEF = 4;

	// result payload always carries four byte lanes
	localparam int OUT_LANES = 4;
	localparam int LANE_W    = 2;
	localparam int COUNT_W   = 3;
	localparam int COPY_W    = 8;
	localparam int LIT_W     = 7;

	localparam logic [7:0] TOKEN_END      = 8'd0;
	localparam logic [7:0] COPY_FLAG_MASK = 8'd128;
	localparam logic [7:0] LEN_MASK       = 8'd127;
	localparam logic [7:0] MIN_COPY       = 8'd3;

	function automatic int lanes_of(input int bpr);
		int n;
		n = bpr;
		if (n > OUT_LANES) n = OUT_LANES;
		if (n < 1) n = 1;
		return n;
	endfunction

endpackage

[sv/lztsd_if.sv]
interface lztsd_byte_if;
	import lztsd_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface lztsd_result_if;
	import lztsd_pkg::*;
	logic               valid;
	logic               ready;
	logic [7:0]         out_byte0;
	logic [7:0]         out_byte1;
	logic [7:0]         out_byte2;
	logic [7:0]         out_byte3;
	logic [COUNT_W-1:0] byte_count;
	logic               run_last;
	logic               stream_end;
	logic               bad_reference;

	modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
		output out_byte3, output byte_count, output run_last, output stream_end,
		output bad_reference, input ready);
	modport sink (input valid, input out_byte0, input out_byte1, input out_byte2,
		input out_byte3, input byte_count, input run_last, input stream_end,
		input bad_reference, output ready);
endinterface

[sv/lz_token_stream_decoder_core.sv]
// Byte-token LZ stream decoder.
// stream: one compressed byte per request (token, literal or offset byte).
// decoded: results of up to four bytes, with byte_count, run_last on the last
//   result an input byte causes, stream_end for a zero token and bad_reference
//   for a rejected copy offset.
// A literal byte, an end token or a rejected offset gives its result from the
// output register in the cycle after the request; such bytes flow at one per
// cycle while the receiver does not stall. Other tokens and the offset low
// byte give no result. A copy starts on the offset high byte and runs through
// the history RAM one byte at a time (registered read, then write-back and
// lane packing), so it holds stream.ready low until its last byte is written;
// the single RAM port pair sets this pace.
// If the receiver stalls, the output register holds its result; stream
// acceptance, and the copy sequencer when it must emit, wait for it to drain.
// Reset clears the parser, write pointer and produced count; the history RAM
// is not cleared, as only bytes written since the last stream end are read.
module lz_token_stream_decoder_core import lztsd_pkg::*; #(
	parameter int HISTORY_DEPTH    = HISTORY_DEPTH_DEF,
	parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lztsd_byte_if.sink   stream,
	lztsd_result_if.source decoded
);

	localparam int AW    = $clog2(HISTORY_DEPTH);
	localparam int PW    = $clog2(HISTORY_DEPTH + 1);
	localparam int CW    = (PW > 16) ? PW : 16;
	localparam int LANES = lanes_of(BYTES_PER_RESULT);
	localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(LANES - 1);
	localparam logic [CW-1:0]     DEPTH_C   = CW'(HISTORY_DEPTH);
	localparam logic [AW:0]       DEPTH_A   = (AW+1)'(HISTORY_DEPTH);
	localparam logic [PW-1:0]     DEPTH_P   = PW'(HISTORY_DEPTH);

	typedef enum logic [3:0] {
		PH_TOKEN   = 4'b0001,
		PH_LITERAL = 4'b0010,
		PH_OFF_LO  = 4'b0100,
		PH_OFF_HI  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		ST_ACCEPT = 3'b001,
		ST_READ   = 3'b010,
		ST_WRITE  = 3'b100
	} state_t;

	phase_t             phase_q;
	state_t             state_q;
	logic [LIT_W-1:0]   lit_left_q;
	logic [COPY_W-1:0]  copy_left_q;
	logic [7:0]         off_lo_q;
	logic [AW-1:0]      dist_q;
	logic [AW-1:0]      wp_q;
	logic [PW-1:0]      produced_q;
	logic [LANE_W-1:0]  lane_q;
	logic [7:0]         acc_q [OUT_LANES];

	logic               out_valid_q;
	logic [7:0]         out_byte_q [OUT_LANES];
	logic [COUNT_W-1:0] out_count_q;
	logic               out_last_q;
	logic               out_end_q;
	logic               out_bad_q;

	logic               out_free;
	logic               take;
	logic [CW-1:0]      off_ext;
	logic [CW-1:0]      dist_w;
	logic               off_bad;
	logic [AW:0]        src_sum;
	logic [AW-1:0]      src_addr;
	logic [AW-1:0]      wp_next;
	logic [PW-1:0]      produced_next;
	logic [7:0]         rd_byte;
	logic               copy_last;
	logic               emit;
	logic               go;
	logic [7:0]         packed_b [OUT_LANES];
	logic               hist_we;
	logic [7:0]         hist_wdata;
	logic               hist_re;

	assign out_free = !out_valid_q || decoded.ready;
	assign stream.ready = (state_q == ST_ACCEPT) && out_free;
	assign take = stream.valid && stream.ready;

	assign off_ext = CW'({stream.data_byte, off_lo_q});
	assign off_bad = (off_ext == '0) || (off_ext > CW'(produced_q));
	assign dist_w  = DEPTH_C - off_ext;

	// source = write pointer minus offset, modulo depth
	always_comb begin
		src_sum = {1'b0, wp_q} + {1'b0, dist_q};
		if (src_sum >= DEPTH_A) begin
			src_sum = src_sum - DEPTH_A;
		end
		src_addr = src_sum[AW-1:0];
	end

	assign wp_next = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
	assign produced_next = (produced_q == DEPTH_P) ? produced_q : produced_q + PW'(1);

	assign copy_last = (copy_left_q == COPY_W'(1));
	assign emit = (lane_q == LANE_LAST) || copy_last;
	assign go   = (state_q == ST_WRITE) && (!emit || out_free);

	always_comb begin
		for (int k = 0; k < OUT_LANES; k++) begin
			if (LANE_W'(k) < lane_q) begin
				packed_b[k] = acc_q[k];
			end else if (LANE_W'(k) == lane_q) begin
				packed_b[k] = rd_byte;
			end else begin
				packed_b[k] = '0;
			end
		end
	end

	assign hist_re = (state_q == ST_READ);
	assign hist_we = go || (take && phase_q == PH_LITERAL);
	assign hist_wdata = go ? rd_byte : stream.data_byte;

	lztsd_history #(
		.DEPTH (HISTORY_DEPTH),
		.AW    (AW)
	) u_history (
		.clk   (clk),
		.we    (hist_we),
		.waddr (wp_q),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (src_addr),
		.rdata (rd_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TOKEN;
			state_q     <= ST_ACCEPT;
			lit_left_q  <= '0;
			copy_left_q <= '0;
			off_lo_q    <= '0;
			dist_q      <= '0;
			wp_q        <= '0;
			produced_q  <= '0;
			lane_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (decoded.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACCEPT: begin
					if (take) begin
						case (phase_q)
							PH_TOKEN: begin
								if (stream.data_byte == TOKEN_END) begin
									out_valid_q <= 1'b1;
									produced_q  <= '0;
								end else if ((stream.data_byte & COPY_FLAG_MASK) != '0) begin
									copy_left_q <= (stream.data_byte & LEN_MASK) + MIN_COPY;
									phase_q     <= PH_OFF_LO;
								end else begin
									lit_left_q <= stream.data_byte[LIT_W-1:0];
									phase_q    <= PH_LITERAL;
								end
							end
							PH_LITERAL: begin
								out_valid_q <= 1'b1;
								wp_q        <= wp_next;
								produced_q  <= produced_next;
								lit_left_q  <= lit_left_q - LIT_W'(1);
								if (lit_left_q == LIT_W'(1)) begin
									phase_q <= PH_TOKEN;
								end
							end
							PH_OFF_LO: begin
								off_lo_q <= stream.data_byte;
								phase_q  <= PH_OFF_HI;
							end
							PH_OFF_HI: begin
								phase_q <= PH_TOKEN;
								if (off_bad) begin
									out_valid_q <= 1'b1;
								end else begin
									dist_q  <= dist_w[AW-1:0];
									lane_q  <= '0;
									state_q <= ST_READ;
								end
							end
							default: begin
								phase_q <= PH_TOKEN;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (go) begin
						wp_q        <= wp_next;
						produced_q  <= produced_next;
						copy_left_q <= copy_left_q - COPY_W'(1);
						lane_q      <= emit ? '0 : lane_q + LANE_W'(1);
						if (emit) begin
							out_valid_q <= 1'b1;
						end
						state_q <= copy_last ? ST_ACCEPT : ST_READ;
					end
				end
				default: begin
					state_q <= ST_ACCEPT;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (go) begin
			for (int k = 0; k < OUT_LANES; k++) begin
				acc_q[k] <= packed_b[k];
			end
			if (emit) begin
				for (int k = 0; k < OUT_LANES; k++) begin
					out_byte_q[k] <= packed_b[k];
				end
				out_count_q <= COUNT_W'(lane_q) + COUNT_W'(1);
				out_last_q  <= copy_last;
				out_end_q   <= 1'b0;
				out_bad_q   <= 1'b0;
			end
		end else if (take) begin
			for (int k = 0; k < OUT_LANES; k++) begin
				out_byte_q[k] <= '0;
			end
			out_count_q <= '0;
			out_last_q  <= 1'b1;
			out_end_q   <= 1'b0;
			out_bad_q   <= 1'b0;
			if (phase_q == PH_LITERAL) begin
				out_byte_q[0] <= stream.data_byte;
				out_count_q   <= COUNT_W'(1);
			end else if (phase_q == PH_TOKEN) begin
				out_end_q <= 1'b1;
			end else begin
				out_bad_q <= 1'b1;
			end
		end
	end

	assign decoded.valid         = out_valid_q;
	assign decoded.out_byte0     = out_byte_q[0];
	assign decoded.out_byte1     = out_byte_q[1];
	assign decoded.out_byte2     = out_byte_q[2];
	assign decoded.out_byte3     = out_byte_q[3];
	assign decoded.byte_count    = out_count_q;
	assign decoded.run_last      = out_last_q;
	assign decoded.stream_end    = out_end_q;
	assign decoded.bad_reference = out_bad_q;

endmodule

[sv/lztsd_history.sv]
module lztsd_history import lztsd_pkg::*; #(
	parameter int DEPTH = HISTORY_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[tb/sv/tb_top.sv]
module tb_top import lztsd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 280;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int TAIL_CYCLES = 300;
	localparam int LANES = (BYTES_PER_RESULT_DEF > OUT_LANES) ? OUT_LANES : BYTES_PER_RESULT_DEF;

	localparam logic [1:0] PH_TOKEN   = 2'd0;
	localparam logic [1:0] PH_LITERAL = 2'd1;
	localparam logic [1:0] PH_OFF_LO  = 2'd2;
	localparam logic [1:0] PH_OFF_HI  = 2'd3;

	typedef struct packed {
		logic [OUT_LANES-1:0][7:0] bytes;
		logic [COUNT_W-1:0]        byte_count;
		logic                      run_last;
		logic                      stream_end;
		logic                      bad_reference;
	} decoded_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	lztsd_byte_if   stream_if ();
	lztsd_result_if result_if ();

	lz_token_stream_decoder_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream_if),
		.decoded (result_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// compressed bytes still to send, decoded beats still owed
	logic [7:0]    stream_q[$];
	decoded_beat_t beats_q[$];
	int            mismatches;
	int            cycles;
	int            gen_produced;

	// decoder state mirror
	logic [1:0]  dec_phase;
	logic [6:0]  lit_left;
	logic [7:0]  copy_len;
	logic [7:0]  off_lo;
	logic [7:0]  history [HISTORY_DEPTH_DEF];
	logic [11:0] wr_ptr;
	logic [12:0] produced;

	task automatic record_byte(input logic [7:0] v);
		history[wr_ptr] = v;
		wr_ptr = wr_ptr + 12'd1;
		if (produced < 13'(HISTORY_DEPTH_DEF))
			produced = produced + 13'd1;
	endtask

	task automatic predict_decode(input logic [7:0] b);
		decoded_beat_t beat;
		logic [15:0]   offset;
		logic [11:0]   src;
		logic [7:0]    v;
		int            lane;
		beat = '0;
		case (dec_phase)
			PH_TOKEN: begin
				if (b == TOKEN_END) begin
					beat.run_last = 1'b1;
					beat.stream_end = 1'b1;
					beats_q.push_back(beat);
					produced = '0;
				end else if ((b & COPY_FLAG_MASK) != 0) begin
					copy_len = (b & LEN_MASK) + MIN_COPY;
					dec_phase = PH_OFF_LO;
				end else begin
					lit_left = 7'(b & LEN_MASK);
					dec_phase = PH_LITERAL;
				end
			end
			PH_LITERAL: begin
				beat.bytes[0] = b;
				beat.byte_count = COUNT_W'(1);
				beat.run_last = 1'b1;
				beats_q.push_back(beat);
				record_byte(b);
				lit_left = lit_left - 7'd1;
				if (lit_left == 0)
					dec_phase = PH_TOKEN;
			end
			PH_OFF_LO: begin
				off_lo = b;
				dec_phase = PH_OFF_HI;
			end
			PH_OFF_HI: begin
				dec_phase = PH_TOKEN;
				offset = {b, off_lo};
				if (offset == 0 || offset > produced) begin
					beat.run_last = 1'b1;
					beat.bad_reference = 1'b1;
					beats_q.push_back(beat);
				end else begin
					lane = 0;
					for (int i = 0; i < copy_len; i++) begin
						// overlapping copies read bytes written earlier in this same copy
						src = wr_ptr - offset[11:0];
						v = history[src];
						beat.bytes[lane] = v;
						beat.byte_count = COUNT_W'(lane + 1);
						record_byte(v);
						lane++;
						if (lane == LANES || i == copy_len - 1) begin
							beat.run_last = (i == copy_len - 1);
							beats_q.push_back(beat);
							beat = '0;
							lane = 0;
						end
					end
				end
				copy_len = '0;
			end
			default: begin
				dec_phase = PH_TOKEN;
			end
		endcase
	endtask

	task automatic check_decoded();
		decoded_beat_t want;
		if (beats_q.size() == 0) begin
			$error("unexpected result: byte_count %0d out_byte0 %0h", result_if.byte_count,
				result_if.out_byte0);
			mismatches++;
		end else begin
			want = beats_q.pop_front();
			if (result_if.out_byte0 !== want.bytes[0]) begin
				$error("out_byte0: expected %0h, got %0h", want.bytes[0], result_if.out_byte0);
				mismatches++;
			end
			if (result_if.out_byte1 !== want.bytes[1]) begin
				$error("out_byte1: expected %0h, got %0h", want.bytes[1], result_if.out_byte1);
				mismatches++;
			end
			if (result_if.out_byte2 !== want.bytes[2]) begin
				$error("out_byte2: expected %0h, got %0h", want.bytes[2], result_if.out_byte2);
				mismatches++;
			end
			if (result_if.out_byte3 !== want.bytes[3]) begin
				$error("out_byte3: expected %0h, got %0h", want.bytes[3], result_if.out_byte3);
				mismatches++;
			end
			if (result_if.byte_count !== want.byte_count) begin
				$error("byte_count: expected %0d, got %0d", want.byte_count,
					result_if.byte_count);
				mismatches++;
			end
			if (result_if.run_last !== want.run_last) begin
				$error("run_last: expected %0b, got %0b", want.run_last, result_if.run_last);
				mismatches++;
			end
			if (result_if.stream_end !== want.stream_end) begin
				$error("stream_end: expected %0b, got %0b", want.stream_end,
					result_if.stream_end);
				mismatches++;
			end
			if (result_if.bad_reference !== want.bad_reference) begin
				$error("bad_reference: expected %0b, got %0b", want.bad_reference,
					result_if.bad_reference);
				mismatches++;
			end
		end
	endtask

	// stream building; gen_produced tracks what a valid offset may reach
	task automatic add_produced(input int n);
		gen_produced = gen_produced + n;
		if (gen_produced > HISTORY_DEPTH_DEF)
			gen_produced = HISTORY_DEPTH_DEF;
	endtask

	task automatic queue_end();
		stream_q.push_back(TOKEN_END);
		gen_produced = 0;
	endtask

	task automatic queue_literals(input int n);
		stream_q.push_back(8'(n));
		for (int i = 0; i < n; i++)
			stream_q.push_back(8'($urandom_range(0, 255)));
		add_produced(n);
	endtask

	task automatic queue_copy(input int len, input int offset);
		stream_q.push_back(COPY_FLAG_MASK | 8'(len - MIN_COPY));
		stream_q.push_back(8'(offset));
		stream_q.push_back(8'(offset >> 8));
		if (offset != 0 && offset <= gen_produced)
			add_produced(len);
	endtask

	task automatic queue_random();
		int pick;
		int len;
		int span;
		pick = $urandom_range(0, 99);
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 130) : $urandom_range(3, 20);
		if (pick < 40 || (pick < 75 && gen_produced == 0)) begin
			queue_literals(($urandom_range(0, 29) == 0) ? 127 : $urandom_range(1, 8));
		end else if (pick < 75) begin
			span = (gen_produced < 16) ? gen_produced : 16;
			case ($urandom_range(0, 3))
				0, 1: queue_copy(len, $urandom_range(1, span));
				2: queue_copy(len, $urandom_range(1, gen_produced));
				default: queue_copy(len, gen_produced);
			endcase
		end else if (pick < 85) begin
			queue_copy(len, ($urandom_range(0, 2) == 0) ? 0 :
				$urandom_range(gen_produced + 1, 65535));
		end else if (pick < 90) begin
			queue_end();
		end else begin
			queue_copy($urandom_range(3, 130), $urandom_range(0, 65535));
		end
	endtask

	// sender: bursts of random length with random gaps
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_if.valid <= 1'b0;
			stream_if.data_byte <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (stream_if.valid && stream_if.ready)
				predict_decode(stream_if.data_byte);
			if (!stream_if.valid || stream_if.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					stream_if.valid <= 1'b0;
				end else if (stream_q.size() != 0) begin
					stream_if.valid <= 1'b1;
					stream_if.data_byte <= stream_q.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					stream_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall mode is redrawn every window
	int       stall_window;
	int       stall_mode;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_window <= 0;
			stall_mode <= 0;
		end else begin
			if (result_if.valid && result_if.ready)
				check_decoded();
			if (stall_window == 0) begin
				stall_window <= $urandom_range(8, 80);
				stall_mode <= $urandom_range(0, 3);
			end else begin
				stall_window <= stall_window - 1;
			end
			case (stall_mode)
				0: result_if.ready <= 1'b1;
				1: result_if.ready <= ($urandom_range(0, 3) != 0);
				2: result_if.ready <= ($urandom_range(0, 3) == 0);
				default: result_if.ready <= !result_if.ready;
			endcase
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		stream_if.valid = 1'b0;
		stream_if.data_byte = '0;
		result_if.ready = 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		cycles = 0;
		gen_produced = 0;
		dec_phase = PH_TOKEN;
		lit_left = '0;
		copy_len = '0;
		off_lo = '0;
		wr_ptr = '0;
		produced = '0;

		// end token with empty history, literal extremes, overlapping copy,
		// longest copy, offset zero / far out / exactly produced / one beyond
		queue_end();
		stream_q.push_back(8'd4);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'hFF);
		stream_q.push_back(8'hA5);
		stream_q.push_back(8'h5A);
		add_produced(4);
		queue_copy(3, 1);
		queue_copy(130, 7);
		queue_copy(4, 0);
		queue_copy(5, 16'hFFFF);
		queue_copy(6, gen_produced);
		queue_copy(7, gen_produced + 1);
		queue_end();

		while (stream_q.size() < ITEM_TARGET)
			queue_random();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (stream_q.size() != 0 || stream_if.valid || beats_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
